/* rtl/uba_pkg.sv */
`default_nettype none

package uba_pkg;

    localparam int NUM_WORDS = 16;
    localparam int WORD_BITS = 64;

    localparam int UNIT_W    = 10;
    localparam int STATUS_W  = 3;
    localparam int UNIT_SPAN = 1 << UNIT_W;

    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIDX_W    = $clog2(WORD_BITS);
    localparam int PAD_BITS  = 1 << BIDX_W;
    localparam int WIDE_W    = $clog2(NUM_WORDS * WORD_BITS) + 1;

    // unit / WORD_BITS by reciprocal, low by at most one, fixed up afterwards
    localparam int DIV_SH    = 16;
    localparam int DIV_RECIP = (1 << DIV_SH) / WORD_BITS;
    localparam int PROD_W    = DIV_SH + UNIT_W;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RESERVE = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_CHECK   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TAKEN = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd4;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [UNIT_W-1:0] unit;
    } uba_req_t;

    typedef struct packed {
        logic [UNIT_W-1:0]   result_unit;
        logic [STATUS_W-1:0] status;
        logic                is_allocated;
    } uba_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ACCESS,
        S_SCAN,
        S_PICK
    } uba_state_t;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_SCAN,
        RD_LOC
    } uba_rd_sel_t;

    typedef struct packed {
        logic        load;
        logic        locate;
        logic        access;
        logic        scan_step;
        logic        scan_hit;
        logic        pick;
        logic        full;
        uba_rd_sel_t rd_sel;
    } uba_cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic word_nz;
        logic scan_last;
    } uba_stat_t;

    // lowest set bit of a nonzero word, by repeated halving
    function automatic logic [BIDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [PAD_BITS-1:0] v;
        logic [PAD_BITS-1:0] lo_mask;
        logic [BIDX_W-1:0]   idx;
        v   = PAD_BITS'(w);
        idx = '0;
        for (int s = BIDX_W - 1; s >= 0; s--)
        begin
            lo_mask = (PAD_BITS'(1) << (1 << s)) - PAD_BITS'(1);
            if ((v & lo_mask) == '0)
            begin
                idx[s] = 1'b1;
                v      = v >> (1 << s);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

/* rtl/uba_ctrl.sv */
`default_nettype none

module uba_ctrl
    import uba_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire uba_stat_t stat,
    output logic           busy,
    output uba_cmd_t       cmd
);

    uba_state_t state_reg;
    uba_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = stat.is_alloc ? S_SCAN : S_DIV;
            end
            S_DIV:    state_next = S_ACCESS;
            S_ACCESS: state_next = S_IDLE;
            S_SCAN:
            begin
                if (stat.word_nz)
                    state_next = S_PICK;
                else if (stat.scan_last)
                    state_next = S_IDLE;
            end
            S_PICK:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        cmd.rd_sel = RD_ZERO;
        busy = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_DIV:
            begin
                cmd.locate = 1'b1;
                cmd.rd_sel = RD_LOC;
            end
            S_ACCESS: cmd.access = 1'b1;
            S_SCAN:
            begin
                cmd.rd_sel = RD_SCAN;
                if (stat.word_nz)
                    cmd.scan_hit = 1'b1;
                else if (stat.scan_last)
                    cmd.full = 1'b1;
                else
                    cmd.scan_step = 1'b1;
            end
            S_PICK:   cmd.pick = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/uba_dp.sv */
`default_nettype none

module uba_dp
    import uba_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire uba_cmd_t          cmd,
    input  wire uba_req_t          req,
    input  wire logic              cfg_we,
    input  wire logic [UNIT_W-1:0] cfg_data,
    output uba_stat_t              stat,
    output logic                   done,
    output uba_res_t               result
);

    // free map: 1 = free; a word never written reads as all free
    logic [WORD_BITS-1:0] map_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] valid_reg;
    logic [WORD_BITS-1:0] rd_word_reg;
    logic                 rd_hit_reg;

    logic [UNIT_W-1:0]    limit_reg;
    logic [1:0]           op_reg;
    logic [UNIT_W-1:0]    unit_reg;
    logic [UNIT_W-1:0]    q0_reg;
    logic [WIDX_W-1:0]    word_idx_reg;
    logic [BIDX_W-1:0]    bit_idx_reg;
    logic                 in_range_reg;
    logic [WIDX_W-1:0]    scan_idx_reg;
    logic [WIDX_W-1:0]    found_word_reg;
    logic [BIDX_W-1:0]    found_bit_reg;
    logic [WORD_BITS-1:0] hold_word_reg;
    logic                 done_reg;
    uba_res_t             result_reg;

    logic [PROD_W-1:0]    q0_prod;
    logic [UNIT_W-1:0]    qd_prod;
    logic [UNIT_W-1:0]    rem0;
    logic [UNIT_W-1:0]    q_fix;
    logic [UNIT_W-1:0]    r_fix;
    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] loc_mask;
    logic [WORD_BITS-1:0] pick_mask;
    logic [WIDE_W-1:0]    found_unit;
    logic                 unit_free;
    logic                 pick_ok;
    logic [WIDX_W-1:0]    rd_addr;
    logic                 map_we;
    logic [WIDX_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    uba_res_t             res_next;

    assign q0_prod = PROD_W'(req.unit) * PROD_W'(DIV_RECIP);

    always_comb
    begin
        qd_prod = UNIT_W'(q0_reg * UNIT_W'(WORD_BITS));
        rem0    = unit_reg - qd_prod;
        if (rem0 >= UNIT_W'(WORD_BITS))
        begin
            q_fix = q0_reg + UNIT_W'(1);
            r_fix = rem0 - UNIT_W'(WORD_BITS);
        end
        else
        begin
            q_fix = q0_reg;
            r_fix = rem0;
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_ZERO: rd_addr = '0;
            RD_SCAN: rd_addr = WIDX_W'(scan_idx_reg + 1'b1);
            RD_LOC:  rd_addr = q_fix[WIDX_W-1:0];
            default: rd_addr = '0;
        endcase
    end

    assign cur_word   = rd_hit_reg ? rd_word_reg : '1;
    assign loc_mask   = WORD_BITS'(1) << bit_idx_reg;
    assign pick_mask  = WORD_BITS'(1) << found_bit_reg;
    assign unit_free  = |(cur_word & loc_mask);
    assign found_unit = WIDE_W'(found_word_reg) * WIDE_W'(WORD_BITS) + WIDE_W'(found_bit_reg);
    assign pick_ok    = (found_unit < WIDE_W'(UNIT_SPAN))
                        && !((limit_reg != '0) && (found_unit > WIDE_W'(limit_reg)));

    assign stat.is_alloc  = cmd.load ? (req.opcode == OP_ALLOC) : (op_reg == OP_ALLOC);
    assign stat.word_nz   = (cur_word != '0);
    assign stat.scan_last = (scan_idx_reg == WIDX_W'(NUM_WORDS - 1));

    always_comb
    begin
        map_we  = 1'b0;
        wr_addr = word_idx_reg;
        wr_data = cur_word;
        if (cmd.access && in_range_reg)
        begin
            if (op_reg == OP_RESERVE && unit_free)
            begin
                map_we  = 1'b1;
                wr_data = cur_word & ~loc_mask;
            end
            else if (op_reg == OP_RELEASE)
            begin
                map_we  = 1'b1;
                wr_data = cur_word | loc_mask;
            end
        end
        else if (cmd.pick && pick_ok)
        begin
            map_we  = 1'b1;
            wr_addr = found_word_reg;
            wr_data = hold_word_reg & ~pick_mask;
        end
    end

    always_comb
    begin
        res_next              = '0;
        res_next.result_unit  = unit_reg;
        res_next.status       = ST_OK;
        res_next.is_allocated = 1'b0;
        if (cmd.access)
        begin
            if (!in_range_reg)
                res_next.status = ST_RANGE;
            else if (op_reg == OP_RESERVE && !unit_free)
                res_next.status = ST_TAKEN;
            else if (op_reg == OP_CHECK)
                res_next.is_allocated = !unit_free;
        end
        else if (cmd.pick)
        begin
            res_next.result_unit = '0;
            if (found_unit >= WIDE_W'(UNIT_SPAN))
                res_next.status = ST_FULL;
            else if (!pick_ok)
                res_next.status = ST_LIMIT;
            else
                res_next.result_unit = found_unit[UNIT_W-1:0];
        end
        else
        begin
            res_next.result_unit = '0;
            res_next.status      = ST_FULL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[wr_addr] <= wr_data;
        rd_word_reg <= map_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
            limit_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (map_we)
                valid_reg[wr_addr] <= 1'b1;
            rd_hit_reg <= valid_reg[rd_addr];
            if (cfg_we)
                limit_reg <= cfg_data;
            done_reg <= cmd.access | cmd.pick | cmd.full;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= req.opcode;
            unit_reg     <= req.unit;
            q0_reg       <= q0_prod[DIV_SH +: UNIT_W];
            scan_idx_reg <= '0;
        end
        if (cmd.locate)
        begin
            word_idx_reg <= q_fix[WIDX_W-1:0];
            bit_idx_reg  <= r_fix[BIDX_W-1:0];
            in_range_reg <= (q_fix < UNIT_W'(NUM_WORDS));
        end
        if (cmd.scan_step)
            scan_idx_reg <= WIDX_W'(scan_idx_reg + 1'b1);
        if (cmd.scan_hit)
        begin
            found_word_reg <= scan_idx_reg;
            found_bit_reg  <= lowest_set(cur_word);
            hold_word_reg  <= cur_word;
        end
        if (cmd.access | cmd.pick | cmd.full)
            result_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* rtl/unit_number_bitmap_allocator_top.sv */
// Reserve, release and check pass through S_DIV and S_ACCESS; the result strobe is registered.
// Allocate scans the map words (1 to 16 of them), one word per cycle through
// the single registered read port, then picks in S_PICK; a full map ends the scan.
// One request at a time: the next is taken in the strobe cycle, and none is taken
// while a request is still in progress; the receiver cannot stall results.
// Reset clears the limit and every per-word valid bit; no clearing pass is needed.
`default_nettype none

module unit_number_bitmap_allocator_top
    import uba_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire uba_req_t          request,
    output logic                   done,
    output uba_res_t               result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [UNIT_W-1:0] cfg_data
);

    uba_cmd_t  cmd;
    uba_stat_t stat;

    assign cfg_ready = 1'b1;

    uba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    uba_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (request),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .stat     (stat),
        .done     (done),
        .result   (result)
    );

endmodule

`default_nettype wire

/* bench/uba_checker.sv */
`default_nettype none

module uba_checker
    import uba_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire uba_req_t          request,
    input  wire logic              done,
    input  wire uba_res_t          result,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [UNIT_W-1:0] cfg_data,
    output int                     errors,
    output int                     pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_BITS = NUM_WORDS * WORD_BITS;

    // 1 marks a free unit
    logic [MAP_BITS-1:0] free_units;
    logic [UNIT_W-1:0]   limit_reg;
    uba_res_t            awaited_results[$];

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    // Work out the outcome of one request and apply it to the map copy.
    function automatic uba_res_t next_outcome(input uba_req_t rq);
        uba_res_t r;
        int       lowest;
        r.result_unit  = rq.unit;
        r.status       = ST_OK;
        r.is_allocated = 1'b0;
        if (rq.opcode == OP_ALLOC)
        begin
            r.result_unit = '0;
            lowest        = -1;
            for (int i = 0; i < MAP_BITS; i++)
            begin
                if (free_units[i] && lowest < 0)
                    lowest = i;
            end
            if (lowest < 0 || lowest >= UNIT_SPAN)
                r.status = ST_FULL;
            else if (limit_reg != '0 && lowest > int'(limit_reg))
                r.status = ST_LIMIT;
            else
            begin
                free_units[lowest] = 1'b0;
                r.result_unit      = UNIT_W'(lowest);
            end
        end
        else if (int'(rq.unit) >= MAP_BITS)
            r.status = ST_RANGE;
        else
        begin
            case (rq.opcode)
                OP_RESERVE:
                begin
                    if (free_units[rq.unit])
                        free_units[rq.unit] = 1'b0;
                    else
                        r.status = ST_TAKEN;
                end
                OP_RELEASE:
                    free_units[rq.unit] = 1'b1;
                OP_CHECK:
                    r.is_allocated = ~free_units[rq.unit];
                default:
                    ;
            endcase
        end
        return r;
    endfunction

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        uba_res_t want;
        if (!rst_n)
        begin
            free_units = '1;
            limit_reg  = '0;
            awaited_results.delete();
        end
        else
        begin
            // compare first so a result and a new transfer on one edge stay ordered
            if (done)
            begin
                if (awaited_results.size() == 0)
                    report_error($sformatf("result with nothing outstanding: unit %0d status %0d",
                                           result.result_unit, result.status));
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.result_unit !== want.result_unit)
                        report_error($sformatf("result_unit %0d, expected %0d",
                                               result.result_unit, want.result_unit));
                    if (result.status !== want.status)
                        report_error($sformatf("status %0d, expected %0d (unit %0d)",
                                               result.status, want.status, want.result_unit));
                    if (result.is_allocated !== want.is_allocated)
                        report_error($sformatf("is_allocated %0b, expected %0b (unit %0d)",
                                               result.is_allocated, want.is_allocated,
                                               want.result_unit));
                end
            end
            if (cfg_valid && cfg_ready)
                limit_reg = cfg_data;
            if (start && !busy)
                awaited_results.push_back(next_outcome(request));
        end
        pending = awaited_results.size();
    end

endmodule

`default_nettype wire

/* bench/tb.sv */
`default_nettype none

module tb;
    import uba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int FILL_ALLOCS = 1030;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    uba_req_t          request;
    logic              done;
    uba_res_t          result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [UNIT_W-1:0] cfg_data;
    int                errors;
    int                pending;
    int                cycles;
    int                sent;
    int                limit_writes;

    unit_number_bitmap_allocator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    uba_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic uba_req_t mk_req(input logic [1:0] op, input logic [UNIT_W-1:0] u);
        uba_req_t r;
        r.opcode = op;
        r.unit   = u;
        return r;
    endfunction

    // Hold start high until the block takes the transfer; start stays high for back-to-back.
    task automatic send(input uba_req_t r);
        @(negedge clk);
        request <= r;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        sent++;
    endtask

    task automatic maybe_idle(input bit allow);
        if (allow && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 2))
                @(negedge clk);
        end
    endtask

    // Drop start, drain every outstanding result, then write the limit.
    task automatic write_limit(input logic [UNIT_W-1:0] v);
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        limit_writes++;
    endtask

    function automatic logic [1:0] pick_op(input int w_alloc, input int w_res, input int w_rel);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < w_alloc)
            return OP_ALLOC;
        if (roll < w_alloc + w_res)
            return OP_RESERVE;
        if (roll < w_alloc + w_res + w_rel)
            return OP_RELEASE;
        return OP_CHECK;
    endfunction

    initial
    begin
        logic [UNIT_W-1:0] lim;
        logic [UNIT_W-1:0] u;
        logic [1:0]        op;
        int                allocs;
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        cycles    = 0;
        sent      = 0;
        limit_writes = 0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: no limit, then a tight limit of 3
        write_limit('0);
        send(mk_req(OP_ALLOC, 10'h3FF));
        send(mk_req(OP_ALLOC, 10'h000));
        send(mk_req(OP_CHECK, 10'd0));
        send(mk_req(OP_CHECK, 10'd1023));
        send(mk_req(OP_RESERVE, 10'd1023));
        send(mk_req(OP_RESERVE, 10'd1023));
        send(mk_req(OP_CHECK, 10'd1023));
        send(mk_req(OP_RELEASE, 10'd1023));
        send(mk_req(OP_RELEASE, 10'd1023));
        send(mk_req(OP_RELEASE, 10'd0));
        send(mk_req(OP_ALLOC, 10'h2AA));
        send(mk_req(OP_RESERVE, 10'd2));
        send(mk_req(OP_ALLOC, 10'h155));
        send(mk_req(OP_CHECK, 10'd512));
        send(mk_req(OP_RESERVE, 10'h2AA));
        send(mk_req(OP_RELEASE, 10'h155));
        send(mk_req(OP_CHECK, 10'h2AA));
        write_limit(10'd3);
        send(mk_req(OP_ALLOC, 10'd0));
        send(mk_req(OP_RELEASE, 10'd1));
        send(mk_req(OP_ALLOC, 10'd0));
        send(mk_req(OP_ALLOC, 10'd0));
        send(mk_req(OP_RELEASE, 10'd3));
        send(mk_req(OP_ALLOC, 10'd0));

        // mixed traffic around a moderate limit, units mostly near the busy region
        lim = UNIT_W'($urandom_range(40, 120));
        write_limit(lim);
        for (int i = 0; i < 220; i++)
        begin
            op = pick_op(40, 20, 25);
            if ($urandom_range(0, 3) != 0)
                u = UNIT_W'($urandom_range(0, int'(lim) + 40));
            else
                u = UNIT_W'($urandom_range(0, 1023));
            send(mk_req(op, u));
            maybe_idle((i % 128) >= 32);
        end

        // fill the whole map; only reserve and check noise in between, so it ends full
        write_limit(10'd1023);
        allocs = 0;
        while (allocs < FILL_ALLOCS)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                op = ($urandom_range(0, 1) == 0) ? OP_RESERVE : OP_CHECK;
                send(mk_req(op, UNIT_W'($urandom_range(0, 1023))));
            end
            else
            begin
                send(mk_req(OP_ALLOC, UNIT_W'($urandom_range(0, 1023))));
                allocs++;
            end
            maybe_idle((allocs % 200) >= 50);
        end
        send(mk_req(OP_RESERVE, UNIT_W'($urandom_range(0, 1023))));

        // drain under the smallest nonzero limit, no idling
        write_limit(10'd1);
        for (int i = 0; i < 100; i++)
        begin
            op = pick_op(35, 15, 40);
            if ($urandom_range(0, 1) == 0)
                u = UNIT_W'($urandom_range(0, 3));
            else
                u = UNIT_W'($urandom_range(0, 1023));
            send(mk_req(op, u));
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (24)
            @(posedge clk);

        $display("Sent %0d requests over %0d limit writes (0, 3, %0d, 1023, 1).",
                 sent, limit_writes, lim);
        $display("Map filled to capacity, then drained under limit 1; %0d cycles.", cycles);
        if (pending != 0)
            $display("%0d results never arrived", pending);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
